>>> design/pmc_pkg.sv
// shared types, widths and codes of the polyline maximum curvature block
package pmc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int XW         = 32;
    localparam int MW         = XW + 1;
    localparam int PW         = 2 * MW;
    localparam int SW         = PW;
    localparam int RW         = SW / 2;
    localparam int CW         = PW;
    localparam int DENW       = 3 * RW + 1;
    localparam int QW         = 32;
    localparam int REM_W      = DENW + QW + 1;
    localparam int NUM_SHIFT  = 2 * FRAC_BITS + 1;
    localparam int SREM_W     = RW + 3;
    localparam int MUL_STEPS  = 9;
    localparam int SQRT_STEPS = RW;
    localparam int DIV_STEPS  = QW;
    localparam int CNT_W      = $clog2(SQRT_STEPS + 1);

    typedef enum logic [3:0] {
        MOP_NONE,
        MOP_DX1,
        MOP_DY1,
        MOP_DX2,
        MOP_DY2,
        MOP_DX3,
        MOP_DY3,
        MOP_P1,
        MOP_P2,
        MOP_AB,
        MOP_ABLO,
        MOP_ABHI
    } t_mop;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_SQRT,
        ST_AB,
        ST_ABW,
        ST_LO,
        ST_HI,
        ST_DENW,
        ST_DIVI,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        t_mop mop;
        logic check;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic div_last;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic window;
        logic zero_side;
        logic div_ovf;
        logic last;
    } t_sts;

    typedef struct packed {
        logic          neg;
        logic [MW-1:0] mag;
    } t_diff;

    function automatic t_diff sub_mag(input logic [XW-1:0] a, input logic [XW-1:0] b);
        logic signed [MW-1:0] d;
        t_diff r;
        d = $signed({a[XW-1], a}) - $signed({b[XW-1], b});
        r.neg = d[MW-1];
        r.mag = d[MW-1] ? MW'(-d) : MW'(d);
        return r;
    endfunction

endpackage

>>> design/pmc_if.sv
// valid/ready channels for sample and result beats
interface pmc_pt_if;
    logic                     valid;
    logic                     ready;
    logic [pmc_pkg::XW-1:0]   point_x;
    logic [pmc_pkg::XW-1:0]   point_y;
    logic [pmc_pkg::XW-1:0]   path_coordinate;
    logic                     last_point;
    modport source (output valid, point_x, point_y, path_coordinate, last_point, input ready);
    modport sink   (input valid, point_x, point_y, path_coordinate, last_point, output ready);
endinterface

interface pmc_res_if;
    logic                     valid;
    logic                     ready;
    logic [pmc_pkg::QW-1:0]   max_curvature;
    logic                     curvature_saturated;
    modport source (output valid, max_curvature, curvature_saturated, input ready);
    modport sink   (input valid, max_curvature, curvature_saturated, output ready);
endinterface

>>> design/polyline_max_curvature.sv
// top level: three-point maximum curvature of a planar polyline
// a sample that completes a window runs the multiplies, root lanes and divider
// (roots and division skipped when a side is zero, division on overflow);
// one sample at a time; 33-step root lanes and a 32-step restoring divider
// a result beat waits in an output register; next sample taken meanwhile
// i_rst_n is synchronous: clears polyline state, end_coordinate to all ones
module polyline_max_curvature (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [pmc_pkg::XW-1:0] i_cfg_wdata,
    pmc_pt_if.sink                 i_pt,
    pmc_res_if.source              o_res
);
    pmc_pkg::t_cmd cmd;
    pmc_pkg::t_sts sts;

    pmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pt.valid),
        .o_in_ready  (i_pt.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pmc_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_wdata           (i_cfg_wdata),
        .i_point_x             (i_pt.point_x),
        .i_point_y             (i_pt.point_y),
        .i_path_coordinate     (i_pt.path_coordinate),
        .i_last_point          (i_pt.last_point),
        .i_cmd                 (cmd),
        .o_sts                 (sts),
        .o_max_curvature       (o_res.max_curvature),
        .o_curvature_saturated (o_res.curvature_saturated)
    );
endmodule

>>> design/pmc_ctrl.sv
// sequencer for window evaluation, square roots and division
module pmc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  pmc_pkg::t_sts i_sts,
    output pmc_pkg::t_cmd o_cmd
);
    pmc_pkg::t_state r_state, n_state;
    logic [pmc_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic r_out_valid, n_out_valid;
    logic accept, slot_free;

    assign o_in_ready  = (r_state == pmc_pkg::ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            pmc_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (accept) begin
                    n_state = i_sts.window ? pmc_pkg::ST_MUL : pmc_pkg::ST_FIN;
                end
            end
            pmc_pkg::ST_MUL: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == pmc_pkg::CNT_W'(pmc_pkg::MUL_STEPS - 1)) begin
                    n_state = pmc_pkg::ST_CHECK;
                end
            end
            pmc_pkg::ST_CHECK: begin
                n_cnt   = '0;
                n_state = i_sts.zero_side ? pmc_pkg::ST_FIN : pmc_pkg::ST_SQRT;
            end
            pmc_pkg::ST_SQRT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == pmc_pkg::CNT_W'(pmc_pkg::SQRT_STEPS - 1)) begin
                    n_state = pmc_pkg::ST_AB;
                end
            end
            pmc_pkg::ST_AB:   n_state = pmc_pkg::ST_ABW;
            pmc_pkg::ST_ABW:  n_state = pmc_pkg::ST_LO;
            pmc_pkg::ST_LO:   n_state = pmc_pkg::ST_HI;
            pmc_pkg::ST_HI:   n_state = pmc_pkg::ST_DENW;
            pmc_pkg::ST_DENW: n_state = pmc_pkg::ST_DIVI;
            pmc_pkg::ST_DIVI: begin
                n_cnt   = '0;
                n_state = i_sts.div_ovf ? pmc_pkg::ST_FIN : pmc_pkg::ST_DIV;
            end
            pmc_pkg::ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == pmc_pkg::CNT_W'(pmc_pkg::DIV_STEPS - 1)) begin
                    n_state = pmc_pkg::ST_FIN;
                end
            end
            pmc_pkg::ST_FIN: begin
                if (!i_sts.last || slot_free) begin
                    n_state = pmc_pkg::ST_IDLE;
                end
            end
            default: n_state = pmc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.mop = pmc_pkg::MOP_NONE;
        case (r_state)
            pmc_pkg::ST_IDLE: o_cmd.load = accept;
            pmc_pkg::ST_MUL: begin
                case (r_cnt)
                    pmc_pkg::CNT_W'(0): o_cmd.mop = pmc_pkg::MOP_DX1;
                    pmc_pkg::CNT_W'(1): o_cmd.mop = pmc_pkg::MOP_DY1;
                    pmc_pkg::CNT_W'(2): o_cmd.mop = pmc_pkg::MOP_DX2;
                    pmc_pkg::CNT_W'(3): o_cmd.mop = pmc_pkg::MOP_DY2;
                    pmc_pkg::CNT_W'(4): o_cmd.mop = pmc_pkg::MOP_DX3;
                    pmc_pkg::CNT_W'(5): o_cmd.mop = pmc_pkg::MOP_DY3;
                    pmc_pkg::CNT_W'(6): o_cmd.mop = pmc_pkg::MOP_P1;
                    pmc_pkg::CNT_W'(7): o_cmd.mop = pmc_pkg::MOP_P2;
                    default:            o_cmd.mop = pmc_pkg::MOP_NONE;
                endcase
            end
            pmc_pkg::ST_CHECK: o_cmd.check     = 1'b1;
            pmc_pkg::ST_SQRT:  o_cmd.sqrt_step = 1'b1;
            pmc_pkg::ST_AB:    o_cmd.mop       = pmc_pkg::MOP_AB;
            pmc_pkg::ST_LO:    o_cmd.mop       = pmc_pkg::MOP_ABLO;
            pmc_pkg::ST_HI:    o_cmd.mop       = pmc_pkg::MOP_ABHI;
            pmc_pkg::ST_DIVI:  o_cmd.div_init  = 1'b1;
            pmc_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_last = (r_cnt == pmc_pkg::CNT_W'(pmc_pkg::DIV_STEPS - 1));
            end
            pmc_pkg::ST_FIN:   o_cmd.emit = i_sts.last && slot_free;
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pmc_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

>>> design/pmc_dp.sv
// datapath: history, shared multiplier, three root lanes, divider, maximum
module pmc_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [pmc_pkg::XW-1:0] i_cfg_wdata,
    input  logic [pmc_pkg::XW-1:0] i_point_x,
    input  logic [pmc_pkg::XW-1:0] i_point_y,
    input  logic [pmc_pkg::XW-1:0] i_path_coordinate,
    input  logic                   i_last_point,
    input  pmc_pkg::t_cmd          i_cmd,
    output pmc_pkg::t_sts          o_sts,
    output logic [pmc_pkg::QW-1:0] o_max_curvature,
    output logic                   o_curvature_saturated
);
    localparam int XW = pmc_pkg::XW;
    localparam int MW = pmc_pkg::MW;

    logic [XW-1:0] r_end;
    logic [XW-1:0] r_hx0, r_hx1, r_hy0, r_hy1, r_prev;
    logic [1:0]    r_seen;
    logic          r_stopped, r_ovf, r_last;
    logic [pmc_pkg::QW-1:0] r_max;

    pmc_pkg::t_diff r_d [6];
    pmc_pkg::t_diff n_d [6];

    logic [pmc_pkg::PW-1:0] r_prod;
    pmc_pkg::t_mop          r_prod_op;
    logic [MW-1:0]          mul_a, mul_b;

    logic [pmc_pkg::SW-1:0] r_sq [3];
    logic [pmc_pkg::PW-1:0] r_p1, r_p2;
    logic [pmc_pkg::CW-1:0] r_cross, n_cross;
    logic [pmc_pkg::PW-1:0] r_ab;
    logic [pmc_pkg::DENW-1:0] r_den;

    logic [pmc_pkg::SW-1:0]     r_rad  [3];
    logic [pmc_pkg::SREM_W-1:0] r_srem [3];
    logic [pmc_pkg::RW-1:0]     r_root [3];

    logic [pmc_pkg::REM_W-1:0] r_rem, dsh, num, rem_sub, n_rem;
    logic [pmc_pkg::QW-1:0]    r_q, n_q;
    logic                      div_ge;

    logic [pmc_pkg::QW-1:0] r_out_max;
    logic                   r_out_sat;

    logic window_base, past_end;

    assign window_base = (r_seen == 2'd2) && !r_stopped;
    assign past_end    = r_prev > r_end;

    // diffs: first->middle, middle->last, first->last
    always_comb begin
        n_d[0] = pmc_pkg::sub_mag(r_hx1, r_hx0);
        n_d[1] = pmc_pkg::sub_mag(r_hy1, r_hy0);
        n_d[2] = pmc_pkg::sub_mag(i_point_x, r_hx1);
        n_d[3] = pmc_pkg::sub_mag(i_point_y, r_hy1);
        n_d[4] = pmc_pkg::sub_mag(i_point_x, r_hx0);
        n_d[5] = pmc_pkg::sub_mag(i_point_y, r_hy0);
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mop)
            pmc_pkg::MOP_DX1: begin mul_a = r_d[0].mag; mul_b = r_d[0].mag; end
            pmc_pkg::MOP_DY1: begin mul_a = r_d[1].mag; mul_b = r_d[1].mag; end
            pmc_pkg::MOP_DX2: begin mul_a = r_d[2].mag; mul_b = r_d[2].mag; end
            pmc_pkg::MOP_DY2: begin mul_a = r_d[3].mag; mul_b = r_d[3].mag; end
            pmc_pkg::MOP_DX3: begin mul_a = r_d[4].mag; mul_b = r_d[4].mag; end
            pmc_pkg::MOP_DY3: begin mul_a = r_d[5].mag; mul_b = r_d[5].mag; end
            pmc_pkg::MOP_P1:  begin mul_a = r_d[0].mag; mul_b = r_d[5].mag; end
            pmc_pkg::MOP_P2:  begin mul_a = r_d[1].mag; mul_b = r_d[4].mag; end
            pmc_pkg::MOP_AB:  begin mul_a = r_root[0];  mul_b = r_root[1];  end
            pmc_pkg::MOP_ABLO: begin
                mul_a = r_ab[MW-1:0];
                mul_b = r_root[2];
            end
            pmc_pkg::MOP_ABHI: begin
                mul_a = r_ab[pmc_pkg::PW-1:MW];
                mul_b = r_root[2];
            end
            default: ;
        endcase
    end

    // cross product magnitude from the two magnitude products
    always_comb begin
        if ((r_d[0].neg ^ r_d[5].neg) != (r_d[1].neg ^ r_d[4].neg)) begin
            n_cross = r_p1 + r_p2;
        end else if (r_p1 >= r_p2) begin
            n_cross = r_p1 - r_p2;
        end else begin
            n_cross = r_p2 - r_p1;
        end
    end

    always_comb begin
        num     = pmc_pkg::REM_W'(r_cross) << pmc_pkg::NUM_SHIFT;
        dsh     = pmc_pkg::REM_W'(r_den) << (pmc_pkg::QW - 1);
        div_ge  = r_rem >= dsh;
        rem_sub = div_ge ? (r_rem - dsh) : r_rem;
        n_rem   = rem_sub << 1;
        n_q     = {r_q[pmc_pkg::QW-2:0], div_ge};
    end

    assign o_sts.window    = window_base && !past_end;
    assign o_sts.zero_side = (r_sq[0] == '0) || (r_sq[1] == '0) || (r_sq[2] == '0);
    assign o_sts.div_ovf   = num >= (pmc_pkg::REM_W'(r_den) << pmc_pkg::QW);
    assign o_sts.last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end <= '1;
        end else if (i_cfg_we) begin
            r_end <= i_cfg_wdata;
        end
    end

    // polyline state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_hx0     <= '0;
            r_hx1     <= '0;
            r_hy0     <= '0;
            r_hy1     <= '0;
            r_prev    <= '0;
            r_seen    <= '0;
            r_stopped <= 1'b0;
            r_max     <= '0;
            r_ovf     <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_hx0  <= r_hx1;
                r_hy0  <= r_hy1;
                r_hx1  <= i_point_x;
                r_hy1  <= i_point_y;
                r_prev <= i_path_coordinate;
                if (r_seen != 2'd2) begin
                    r_seen <= r_seen + 2'd1;
                end
                if (window_base && past_end) begin
                    r_stopped <= 1'b1;
                end
            end
            if (i_cmd.div_init && o_sts.div_ovf) begin
                r_max     <= '1;
                r_ovf     <= 1'b1;
                r_stopped <= 1'b1;
            end
            if (i_cmd.div_last && (n_q > r_max)) begin
                r_max <= n_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= 1'b0;
            r_prod_op <= pmc_pkg::MOP_NONE;
        end else begin
            if (i_cmd.load) begin
                r_last <= i_last_point;
            end
            r_prod_op <= i_cmd.mop;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < 6; i++) begin
                r_d[i] <= n_d[i];
            end
        end
        r_prod <= mul_a * mul_b;
        case (r_prod_op)
            pmc_pkg::MOP_DX1:  r_sq[0] <= r_prod;
            pmc_pkg::MOP_DY1:  r_sq[0] <= r_sq[0] + r_prod;
            pmc_pkg::MOP_DX2:  r_sq[1] <= r_prod;
            pmc_pkg::MOP_DY2:  r_sq[1] <= r_sq[1] + r_prod;
            pmc_pkg::MOP_DX3:  r_sq[2] <= r_prod;
            pmc_pkg::MOP_DY3:  r_sq[2] <= r_sq[2] + r_prod;
            pmc_pkg::MOP_P1:   r_p1    <= r_prod;
            pmc_pkg::MOP_P2:   r_p2    <= r_prod;
            pmc_pkg::MOP_AB:   r_ab    <= r_prod;
            pmc_pkg::MOP_ABLO: r_den   <= pmc_pkg::DENW'(r_prod);
            pmc_pkg::MOP_ABHI: r_den   <= r_den + (pmc_pkg::DENW'(r_prod) << MW);
            default: ;
        endcase
        if (i_cmd.check) begin
            r_cross <= n_cross;
            for (int l = 0; l < 3; l++) begin
                r_rad[l]  <= r_sq[l];
                r_srem[l] <= '0;
                r_root[l] <= '0;
            end
        end
        // one root digit per lane per cycle
        if (i_cmd.sqrt_step) begin
            for (int l = 0; l < 3; l++) begin
                logic [pmc_pkg::SREM_W-1:0] t, trial;
                t     = {r_srem[l][pmc_pkg::SREM_W-3:0], r_rad[l][pmc_pkg::SW-1 -: 2]};
                trial = pmc_pkg::SREM_W'({r_root[l], 2'b01});
                r_rad[l] <= r_rad[l] << 2;
                if (t >= trial) begin
                    r_srem[l] <= t - trial;
                    r_root[l] <= {r_root[l][pmc_pkg::RW-2:0], 1'b1};
                end else begin
                    r_srem[l] <= t;
                    r_root[l] <= {r_root[l][pmc_pkg::RW-2:0], 1'b0};
                end
            end
        end
        if (i_cmd.div_init) begin
            r_rem <= num;
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
        if (i_cmd.emit) begin
            r_out_max <= r_max;
            r_out_sat <= r_ovf;
        end
    end

    assign o_max_curvature       = r_out_max;
    assign o_curvature_saturated = r_out_sat;
endmodule
